/* rtl/core/selu_pkg.sv */
`timescale 1ns / 1ps
// shared/exclusive lock unit: op and status codes, lock state and result types
// no dependencies; used by selu_eval and shared_exclusive_lock_unit

package selu_pkg;

    // parameter defaults
    localparam int ID_BITS_DEF     = 8;
    localparam int MAX_HOLDERS_DEF = 255;

    // field widths
    localparam int OP_W     = 3;
    localparam int REQ_W    = 8;
    localparam int STATUS_W = 3;
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 9;
    localparam int UPG_W    = 8;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;

    // request ops
    localparam logic [OP_W-1:0] OP_TRY_SHARED  = 3'd0;
    localparam logic [OP_W-1:0] OP_TRY_EXCL    = 3'd1;
    localparam logic [OP_W-1:0] OP_UNLOCK      = 3'd2;
    localparam logic [OP_W-1:0] OP_UPGRADE     = 3'd3;
    localparam logic [OP_W-1:0] OP_POLL        = 3'd4;
    localparam logic [OP_W-1:0] OP_DOWNGRADE   = 3'd5;
    localparam logic [OP_W-1:0] OP_RELEASE_UPG = 3'd6;
    localparam logic [OP_W-1:0] OP_SET_OWNER   = 3'd7;

    // answer codes
    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PENDING  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    // lock modes
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHARED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXCL   = 2'd2;

    localparam logic [UPG_W-1:0] UPG_MAX = 8'hFF;

    // lock state apart from the owner id, whose width is a parameter
    typedef struct packed {
        logic signed [COUNT_W-1:0] hold_count;
        logic                      owner_valid;
        logic [UPG_W-1:0]          upgraders;
        logic                      blocked_mark;
    } lock_state_t;

    // one result word
    typedef struct packed {
        logic signed [COUNT_W-1:0] holder_count;
        logic                      owned;
        logic                      wake;
        logic [MODE_W-1:0]         mode_before;
        logic [STATUS_W-1:0]       status;
    } lock_result_t;

endpackage

/* rtl/core/shared_exclusive_lock_unit.sv */
`timescale 1ns / 1ps
// shared/exclusive lock unit top level: request and result registers, lock state
// depends on selu_pkg and selu_eval

// A single lock with shared and exclusive modes, recursion and shared-to-exclusive
// upgrade. Each request word carries an op, a requester id and a prior mode; each
// request gives exactly one result word with status, mode before the op, wake,
// ownership and the signed hold count after the op (negative is exclusive depth).
// The unit never waits: a refused request answers busy or upgrade pending and sets
// a blocked mark, and the next release that clears the mark raises wake so that
// waiters retry. Requests that break the lock rules answer error and leave the
// state alone. Throughput is one request word per cycle while result words are
// taken: a request sits in the input register, the lock state and the result are
// worked out from it in one combinational pass, and the lock registers and the
// result register load at the same edge, so the next request already sees the
// updated lock. The result word is offered from the result register. While a
// result word waits, the request register still takes one more word; s_tready then
// stays low until the result word is taken, and rises in the cycle it is taken.
// Only the low ID_BITS of the requester take part in ownership; hold counts and
// exclusive depth are limited to the smaller of MAX_HOLDERS and 255.

module shared_exclusive_lock_unit #(
    parameter int ID_BITS     = selu_pkg::ID_BITS_DEF,
    parameter int MAX_HOLDERS = selu_pkg::MAX_HOLDERS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request side
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // op[2:0], requester[10:3], prior_mode[11], zero fill[15:12]
    input  logic [selu_pkg::IN_W-1:0]   s_tdata,
    // result side
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // status[2:0], mode_before[4:3], wake[5], owned[6], holder_count[15:7]
    output logic [selu_pkg::OUT_W-1:0]  m_tdata
);

    localparam int HOLD_LIMIT = (MAX_HOLDERS > 255) ? 255 : MAX_HOLDERS;

    // request register
    logic                            in_valid_reg;
    logic [selu_pkg::OP_W-1:0]       in_op_reg;
    logic [selu_pkg::REQ_W-1:0]      in_req_reg;
    logic                            in_prior_reg;

    // lock state
    selu_pkg::lock_state_t           lock_reg;
    selu_pkg::lock_state_t           lock_next;
    logic [ID_BITS-1:0]              owner_reg;
    logic [ID_BITS-1:0]              owner_next;

    // result register
    logic                            out_valid_reg;
    selu_pkg::lock_result_t          out_res_reg;
    selu_pkg::lock_result_t          res_next;

    logic                            fire;
    logic [ID_BITS+selu_pkg::REQ_W-1:0] req_ext;
    logic [ID_BITS-1:0]              who;

    // a request is evaluated when the result slot is empty or being emptied
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

    // requester id cut or zero-extended to the owner width
    assign req_ext = {{ID_BITS{1'b0}}, in_req_reg};
    assign who     = req_ext[ID_BITS-1:0];

    selu_eval #(
        .ID_BITS     (ID_BITS),
        .MAX_HOLDERS (MAX_HOLDERS)
    ) u_eval (
        .op           (in_op_reg),
        .who          (who),
        .prior_shared (in_prior_reg),
        .cur          (lock_reg),
        .cur_owner    (owner_reg),
        .nxt          (lock_next),
        .nxt_owner    (owner_next),
        .res          (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lock_reg      <= '0;
            owner_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (fire)
            begin
                lock_reg      <= lock_next;
                owner_reg     <= owner_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg    <= s_tdata[2:0];
            in_req_reg   <= s_tdata[10:3];
            in_prior_reg <= s_tdata[11];
        end
        if (fire)
            out_res_reg <= res_next;
    end

    // an owner is recorded exactly while the lock is held exclusively
    a_owner_mode: assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg.owner_valid == (lock_reg.hold_count < 0))
        else $error("owner record out of step with exclusive mode");

    // hold count never leaves the configured limit in either direction
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (lock_reg.hold_count <= 10'(HOLD_LIMIT))
        && (lock_reg.hold_count >= -10'(HOLD_LIMIT)))
        else $error("hold count beyond limit");

    // lock state only moves when a request is evaluated
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(lock_reg) && $stable(owner_reg))
        else $error("lock state changed without a request");

    // the blocked mark is cleared only by a release that reports wake
    a_wake_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && lock_reg.blocked_mark && !lock_next.blocked_mark |-> res_next.wake)
        else $error("blocked mark cleared without wake");

    // a reported wake always comes from a set blocked mark
    a_wake_src: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_next.wake |-> lock_reg.blocked_mark)
        else $error("wake raised with no blocked mark");

endmodule

/* rtl/core/selu_eval.sv */
`timescale 1ns / 1ps
// shared/exclusive lock unit: next lock state and result for one request
// depends on selu_pkg

module selu_eval #(
    parameter int ID_BITS     = selu_pkg::ID_BITS_DEF,
    parameter int MAX_HOLDERS = selu_pkg::MAX_HOLDERS_DEF
) (
    input  logic [selu_pkg::OP_W-1:0]  op,
    input  logic [ID_BITS-1:0]         who,
    input  logic                       prior_shared,
    input  selu_pkg::lock_state_t      cur,
    input  logic [ID_BITS-1:0]         cur_owner,
    output selu_pkg::lock_state_t      nxt,
    output logic [ID_BITS-1:0]         nxt_owner,
    output selu_pkg::lock_result_t     res
);

    localparam int HOLD_LIMIT = (MAX_HOLDERS > 255) ? 255 : MAX_HOLDERS;
    localparam logic signed [selu_pkg::COUNT_W:0] LIMIT_S = 10'(HOLD_LIMIT);

    logic                               is_owner;
    logic                               hc_neg;
    logic                               hc_pos;
    logic signed [selu_pkg::COUNT_W:0]  hc_ext;
    logic signed [selu_pkg::COUNT_W:0]  depth;

    // full unlock
    selu_pkg::lock_state_t              unl_st;
    logic [ID_BITS-1:0]                 unl_owner;
    logic [selu_pkg::STATUS_W-1:0]      unl_status;
    logic                               unl_wake;
    logic                               unl_idle;

    // end of upgrade
    selu_pkg::lock_state_t              end_st;
    logic [ID_BITS-1:0]                 end_owner;
    logic [selu_pkg::STATUS_W-1:0]      end_status;
    logic                               end_wake;

    logic [selu_pkg::STATUS_W-1:0]      status;
    logic                               wake;

    assign hc_neg   = cur.hold_count < 0;
    assign hc_pos   = cur.hold_count > 0;
    assign hc_ext   = {cur.hold_count[selu_pkg::COUNT_W-1], cur.hold_count};
    assign depth    = -hc_ext;
    assign is_owner = hc_neg && cur.owner_valid && (cur_owner == who);

    always_comb
    begin
        unl_st     = cur;
        unl_owner  = cur_owner;
        unl_status = selu_pkg::ST_GRANTED;
        unl_wake   = 1'b0;
        unl_idle   = 1'b0;
        if (hc_neg)
        begin
            if (!is_owner)
            begin
                unl_status = selu_pkg::ST_ERROR;
            end
            else if (cur.hold_count < -9'sd1)
            begin
                unl_st.hold_count = cur.hold_count + 9'sd1;
            end
            else
            begin
                unl_st.hold_count   = '0;
                unl_st.owner_valid  = 1'b0;
                unl_owner           = '0;
                unl_wake            = cur.blocked_mark;
                unl_st.blocked_mark = 1'b0;
            end
        end
        else if (hc_pos)
        begin
            unl_st.hold_count = cur.hold_count - 9'sd1;
            if (cur.hold_count == 9'sd1)
            begin
                unl_wake            = cur.blocked_mark;
                unl_st.blocked_mark = 1'b0;
            end
        end
        else
        begin
            unl_idle = 1'b1;
        end
    end

    always_comb
    begin
        end_st     = cur;
        end_owner  = cur_owner;
        end_status = selu_pkg::ST_GRANTED;
        end_wake   = 1'b0;
        if (cur.hold_count != -9'sd1 || !is_owner)
        begin
            end_status = selu_pkg::ST_ERROR;
        end
        else
        begin
            if (cur.upgraders != '0)
            begin
                end_st.upgraders = cur.upgraders - 8'd1;
            end
            // downgrade keeps one shared hold, release drops it
            end_st.hold_count   = (op == selu_pkg::OP_DOWNGRADE) ? 9'sd1 : 9'sd0;
            end_st.owner_valid  = 1'b0;
            end_owner           = '0;
            end_wake            = cur.blocked_mark;
            end_st.blocked_mark = 1'b0;
        end
    end

    always_comb
    begin
        nxt       = cur;
        nxt_owner = cur_owner;
        status    = selu_pkg::ST_GRANTED;
        wake      = 1'b0;
        case (op)
            selu_pkg::OP_TRY_SHARED, selu_pkg::OP_TRY_EXCL:
            begin
                if (is_owner)
                begin
                    // recursion deepens the exclusive hold
                    if (depth >= LIMIT_S)
                        status = selu_pkg::ST_OVERFLOW;
                    else
                        nxt.hold_count = cur.hold_count - 9'sd1;
                end
                else if (op == selu_pkg::OP_TRY_SHARED)
                begin
                    if (hc_neg || cur.upgraders != '0)
                    begin
                        nxt.blocked_mark = 1'b1;
                        status           = selu_pkg::ST_BUSY;
                    end
                    else if (cur.owner_valid)
                        status = selu_pkg::ST_ERROR;
                    else if (hc_ext >= LIMIT_S)
                        status = selu_pkg::ST_OVERFLOW;
                    else
                        nxt.hold_count = cur.hold_count + 9'sd1;
                end
                else
                begin
                    if (cur.hold_count != '0 || cur.upgraders != '0)
                    begin
                        nxt.blocked_mark = 1'b1;
                        status           = selu_pkg::ST_BUSY;
                    end
                    else
                    begin
                        nxt.hold_count  = -9'sd1;
                        nxt.owner_valid = 1'b1;
                        nxt_owner       = who;
                    end
                end
            end
            selu_pkg::OP_UNLOCK:
            begin
                nxt       = unl_st;
                nxt_owner = unl_owner;
                status    = unl_status;
                wake      = unl_wake;
            end
            selu_pkg::OP_UPGRADE:
            begin
                if (hc_neg)
                begin
                    if (!is_owner)
                        status = selu_pkg::ST_ERROR;
                end
                else if (hc_pos)
                begin
                    if (cur.upgraders == selu_pkg::UPG_MAX)
                        status = selu_pkg::ST_OVERFLOW;
                    else
                    begin
                        nxt.upgraders  = cur.upgraders + 8'd1;
                        nxt.hold_count = cur.hold_count - 9'sd1;
                        if (cur.hold_count == 9'sd1)
                        begin
                            nxt.hold_count  = -9'sd1;
                            nxt.owner_valid = 1'b1;
                            nxt_owner       = who;
                        end
                        else
                        begin
                            nxt.blocked_mark = 1'b1;
                            status           = selu_pkg::ST_PENDING;
                        end
                    end
                end
                else
                    status = selu_pkg::ST_ERROR;
            end
            selu_pkg::OP_POLL:
            begin
                if (cur.upgraders == '0)
                    status = selu_pkg::ST_ERROR;
                else if (cur.hold_count == '0)
                begin
                    nxt.hold_count  = -9'sd1;
                    nxt.owner_valid = 1'b1;
                    nxt_owner       = who;
                end
                else
                begin
                    nxt.blocked_mark = 1'b1;
                    status           = selu_pkg::ST_PENDING;
                end
            end
            selu_pkg::OP_DOWNGRADE:
            begin
                if (prior_shared)
                begin
                    nxt       = end_st;
                    nxt_owner = end_owner;
                    status    = end_status;
                    wake      = end_wake;
                end
            end
            selu_pkg::OP_RELEASE_UPG:
            begin
                if (prior_shared)
                begin
                    nxt       = end_st;
                    nxt_owner = end_owner;
                    status    = end_status;
                    wake      = end_wake;
                end
                else
                begin
                    nxt       = unl_st;
                    nxt_owner = unl_owner;
                    wake      = unl_wake;
                    status    = unl_idle ? selu_pkg::ST_ERROR : unl_status;
                end
            end
            selu_pkg::OP_SET_OWNER:
            begin
                if (hc_neg)
                begin
                    nxt.owner_valid = 1'b1;
                    nxt_owner       = who;
                end
                else
                    status = selu_pkg::ST_ERROR;
            end
            default:
            begin
                status = selu_pkg::ST_ERROR;
            end
        endcase
    end

    always_comb
    begin
        res.status       = status;
        res.mode_before  = hc_neg ? selu_pkg::MODE_EXCL
                         : (hc_pos ? selu_pkg::MODE_SHARED : selu_pkg::MODE_NONE);
        res.wake         = wake;
        res.owned        = (nxt.hold_count < 0) && nxt.owner_valid && (nxt_owner == who);
        res.holder_count = nxt.hold_count;
    end

endmodule
